@@ hw/rtl/gls_pkg.sv @@
package gls_pkg;

  localparam int SUM_W = 29;
  localparam int CNT_W = 13;
  localparam int DIM_W = 13;
  localparam int THR_W = 16;
  localparam int LUMA_W = 16;
  localparam int DIV_W = 29;
  localparam int DVR_W = 13;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HIGHLIGHT_THRESHOLD = 2'd2;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST = 13'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [THR_W-1:0] HIGHLIGHT_THRESHOLD_RST = 16'd57105;

  localparam logic [15:0] W_RED = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE = 16'd4732;
  localparam logic [47:0] LUMA_RND = 48'd8355840;

  // Division by 255 as a multiply by ceil(2^33 / 255) and a shift; exact for operands below 2^25.
  localparam logic [31:0] ALPHA_RECIP = 32'd33686019;
  localparam int ALPHA_RECIP_SH = 33;

  typedef struct packed {
    logic [31:0] argb;
    logic        frame_start;
  } in_t;

  typedef struct packed {
    logic [5:0]  cell_column;
    logic [5:0]  cell_row;
    logic [15:0] mean_luma;
    logic        cell_valid;
    logic        highlight;
    logic        last;
  } out_t;

  typedef struct packed {
    logic             go;
    logic [DIV_W-1:0] dividend;
    logic [DVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef logic [15:0] lin_rom_t [256];

  function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b + 64'd536870912) >> 30;
  endfunction

  function automatic logic [63:0] q30_pow5(input logic [63:0] r);
    logic [63:0] r2;
    logic [63:0] r4;
    r2 = q30_mul(r, r);
    r4 = q30_mul(r2, r2);
    return q30_mul(r4, r);
  endfunction

  function automatic lin_rom_t build_lin_rom();
    lin_rom_t    rom;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] v;
    for (int i = 0; i < 256; i++) begin
      if (i <= 10) begin
        rom[i] = 16'((64'(i) * 64'd6553600 + 64'd164730) / 64'd329460);
      end else begin
        t = (((64'(i) * 64'd1000 + 64'd14025) << 30) + 64'd134512) / 64'd269025;
        t2 = q30_mul(t, t);
        lo = 64'd0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
          mid = lo + (hi - lo + 64'd1) / 64'd2;
          if (q30_pow5(mid) <= t2) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
        v = (q30_mul(t2, lo) + 64'd8192) >> 14;
        rom[i] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
      end
    end
    return rom;
  endfunction

  localparam lin_rom_t LIN_ROM = build_lin_rom();

endpackage

@@ hw/rtl/gls_ram.sv @@
module gls_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/gls_div.sv @@
module gls_div (
  input  logic                clk,
  input  logic                rst_n,
  input  gls_pkg::div_req_t   req,
  output gls_pkg::div_rsp_t   rsp
);
  import gls_pkg::*;

  localparam int CNT_BITS = $clog2(DIV_W);

  logic                busy_r;
  logic                done_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [DIV_W-1:0]    quo_r;
  logic [DVR_W-1:0]    rem_r;
  logic [DVR_W-1:0]    dvr_r;
  logic [DVR_W:0]      trial;
  logic [DVR_W:0]      diff;
  logic                take;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff = trial - {1'b0, dvr_r};
  assign take = trial >= {1'b0, dvr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvr_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], take};
      rem_r <= take ? diff[DVR_W-1:0] : trial[DVR_W-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.quotient = quo_r;

endmodule

@@ hw/rtl/grid_luma_statistics_top.sv @@
// Per-cell mean of display-linear luma on a GRID_COLUMNS x GRID_ROWS grid. Each pixel transaction
// passes through the accept state, two divisions on the one shared restoring divider (grid row
// and grid column), four multiply steps for the luma, one reciprocal multiply for the alpha
// scaling and the accumulate step. Every image row end but the last one of a frame adds a
// division for the next grid row. After the last pixel of a cell row the block emits
// GRID_COLUMNS cell means, each with its memory read and, for a non-empty cell, a division, and
// each held until out_ready takes it, and in_ready stays low until the last one has been taken.
module grid_luma_statistics_top #(
  parameter int GRID_COLUMNS = 64,
  parameter int GRID_ROWS = 48,
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  gls_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gls_pkg::out_t                       out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gls_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [gls_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [gls_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import gls_pkg::*;

  localparam int IDX_W = $clog2(GRID_COLUMNS);
  localparam int GY_W = $clog2(GRID_ROWS);
  localparam int PX_W = $clog2(MAX_WIDTH);
  localparam int PY_W = $clog2(MAX_HEIGHT);
  localparam int RAM_W = SUM_W + CNT_W;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_GY = 4'd1;
  localparam logic [3:0] ST_GX = 4'd2;
  localparam logic [3:0] ST_M0 = 4'd3;
  localparam logic [3:0] ST_M1 = 4'd4;
  localparam logic [3:0] ST_M2 = 4'd5;
  localparam logic [3:0] ST_M3 = 4'd6;
  localparam logic [3:0] ST_LD = 4'd7;
  localparam logic [3:0] ST_ACC = 4'd8;
  localparam logic [3:0] ST_GN = 4'd9;
  localparam logic [3:0] ST_EA = 4'd10;
  localparam logic [3:0] ST_ED = 4'd11;
  localparam logic [3:0] ST_EM = 4'd12;
  localparam logic [3:0] ST_EO = 4'd13;

  logic [3:0]              state_r, state_nxt;
  logic                    div_go_r, div_go_nxt;
  logic [DIM_W-1:0]        frame_width_r, frame_height_r;
  logic [THR_W-1:0]        threshold_r;
  logic [31:0]             argb_r, argb_nxt;
  logic [PX_W-1:0]         px_r, px_nxt;
  logic [PY_W-1:0]         py_r, py_nxt;
  logic [IDX_W-1:0]        gx_r, gx_nxt;
  logic [GY_W-1:0]         gy_r, gy_nxt;
  logic [47:0]             acc_r, acc_nxt;
  logic [LUMA_W-1:0]       luma_r, luma_nxt;
  logic [GRID_COLUMNS-1:0] col_vld_r, col_vld_nxt;
  logic [IDX_W-1:0]        col_r, col_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_t                    out_r, out_nxt;

  logic [DIM_W-1:0]        w_dim, h_dim;
  logic [31:0]             mul_a;
  logic [31:0]             mul_b;
  logic [63:0]             prod;
  logic [15:0]             rom_val;
  div_req_t                div_req;
  div_rsp_t                div_rsp;
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_raddr;
  logic [RAM_W-1:0]        ram_wdata, ram_rdata;
  logic [SUM_W-1:0]        old_sum, rd_sum;
  logic [CNT_W-1:0]        old_cnt, rd_cnt;
  logic [GY_W-1:0]         gy_sat;
  logic [IDX_W-1:0]        gx_sat;
  logic [15:0]             mean_sat;
  logic                    cfg_wr;

  assign w_dim = ({1'b0, frame_width_r} < 14'(GRID_COLUMNS)) ? DIM_W'(GRID_COLUMNS) :
                 ({1'b0, frame_width_r} > 14'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : frame_width_r;
  assign h_dim = ({1'b0, frame_height_r} < 14'(GRID_ROWS)) ? DIM_W'(GRID_ROWS) :
                 ({1'b0, frame_height_r} > 14'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : frame_height_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_FRAME_WIDTH: prdata = CFG_DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(frame_height_r);
      REG_HIGHLIGHT_THRESHOLD: prdata = CFG_DATA_W'(threshold_r);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      threshold_r <= HIGHLIGHT_THRESHOLD_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_FRAME_WIDTH: frame_width_r <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[DIM_W-1:0];
        REG_HIGHLIGHT_THRESHOLD: threshold_r <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (state_r)
      ST_M0: rom_val = LIN_ROM[argb_r[23:16]];
      ST_M1: rom_val = LIN_ROM[argb_r[15:8]];
      default: rom_val = LIN_ROM[argb_r[7:0]];
    endcase
    case (state_r)
      ST_M0: mul_b = {16'd0, W_RED};
      ST_M1: mul_b = {16'd0, W_GREEN};
      ST_M2: mul_b = {16'd0, W_BLUE};
      ST_LD: mul_b = ALPHA_RECIP;
      default: mul_b = {24'd0, argb_r[31:24]};
    endcase
    case (state_r)
      ST_M3: mul_a = acc_r[31:0];
      ST_LD: mul_a = {7'd0, acc_r[40:16]};
      default: mul_a = {16'd0, rom_val};
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    div_req.go = div_go_r;
    case (state_r)
      ST_GX: begin
        div_req.dividend = DIV_W'(GRID_COLUMNS * int'(px_r));
        div_req.divisor = w_dim;
      end
      ST_EM: begin
        div_req.dividend = rd_sum;
        div_req.divisor = rd_cnt;
      end
      default: begin
        div_req.dividend = DIV_W'(GRID_ROWS * int'(py_r));
        div_req.divisor = h_dim;
      end
    endcase
  end

  gls_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign gy_sat = (div_rsp.quotient >= DIV_W'(GRID_ROWS)) ? GY_W'(GRID_ROWS - 1) :
                  div_rsp.quotient[GY_W-1:0];
  assign gx_sat = (div_rsp.quotient >= DIV_W'(GRID_COLUMNS)) ? IDX_W'(GRID_COLUMNS - 1) :
                  div_rsp.quotient[IDX_W-1:0];
  assign mean_sat = (div_rsp.quotient > DIV_W'(16'hFFFF)) ? 16'hFFFF : div_rsp.quotient[15:0];

  assign ram_raddr = (state_r == ST_EA || state_r == ST_ED || state_r == ST_EM ||
                      state_r == ST_EO) ? col_r : gx_r;
  assign rd_sum = col_vld_r[col_r] ? ram_rdata[RAM_W-1:CNT_W] : '0;
  assign rd_cnt = col_vld_r[col_r] ? ram_rdata[CNT_W-1:0] : '0;
  assign old_sum = col_vld_r[gx_r] ? ram_rdata[RAM_W-1:CNT_W] : '0;
  assign old_cnt = col_vld_r[gx_r] ? ram_rdata[CNT_W-1:0] : '0;
  assign ram_we = (state_r == ST_ACC) && (argb_r[31:24] != 8'd0);
  assign ram_wdata = {old_sum + SUM_W'(luma_r), old_cnt + 1'b1};

  gls_ram #(
    .WIDTH (RAM_W),
    .DEPTH (GRID_COLUMNS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (gx_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    div_go_nxt = 1'b0;
    argb_nxt = argb_r;
    px_nxt = px_r;
    py_nxt = py_r;
    gx_nxt = gx_r;
    gy_nxt = gy_r;
    acc_nxt = acc_r;
    luma_nxt = luma_r;
    col_vld_nxt = col_vld_r;
    col_nxt = col_r;
    out_valid_nxt = out_valid_r;
    out_nxt = out_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          argb_nxt = in_data.argb;
          if (in_data.frame_start) begin
            px_nxt = '0;
            py_nxt = '0;
            col_vld_nxt = '0;
          end
          div_go_nxt = 1'b1;
          state_nxt = ST_GY;
        end
      end
      ST_GY: begin
        if (div_rsp.done) begin
          gy_nxt = gy_sat;
          div_go_nxt = 1'b1;
          state_nxt = ST_GX;
        end
      end
      ST_GX: begin
        if (div_rsp.done) begin
          gx_nxt = gx_sat;
          state_nxt = ST_M0;
        end
      end
      ST_M0: begin
        acc_nxt = prod[47:0];
        state_nxt = ST_M1;
      end
      ST_M1: begin
        acc_nxt = acc_r + prod[47:0];
        state_nxt = ST_M2;
      end
      ST_M2: begin
        acc_nxt = acc_r + prod[47:0];
        state_nxt = ST_M3;
      end
      ST_M3: begin
        acc_nxt = prod[47:0] + LUMA_RND;
        state_nxt = ST_LD;
      end
      ST_LD: begin
        luma_nxt = prod[ALPHA_RECIP_SH +: LUMA_W];
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (ram_we) begin
          col_vld_nxt[gx_r] = 1'b1;
        end
        if ({1'b0, px_r} + 1'b1 >= (PX_W + 1)'(w_dim)) begin
          px_nxt = '0;
          if ({1'b0, py_r} + 1'b1 >= (PY_W + 1)'(h_dim)) begin
            py_nxt = '0;
            col_nxt = '0;
            state_nxt = ST_EA;
          end else begin
            py_nxt = py_r + 1'b1;
            div_go_nxt = 1'b1;
            state_nxt = ST_GN;
          end
        end else begin
          px_nxt = px_r + 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_GN: begin
        if (div_rsp.done) begin
          if (gy_sat != gy_r) begin
            col_nxt = '0;
            state_nxt = ST_EA;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EA: begin
        state_nxt = ST_ED;
      end
      ST_ED: begin
        out_nxt.cell_column = 6'(col_r);
        out_nxt.cell_row = 6'(gy_r);
        out_nxt.last = (col_r == IDX_W'(GRID_COLUMNS - 1));
        if (rd_cnt != '0) begin
          div_go_nxt = 1'b1;
          state_nxt = ST_EM;
        end else begin
          out_nxt.mean_luma = '0;
          out_nxt.cell_valid = 1'b0;
          out_nxt.highlight = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt = ST_EO;
        end
      end
      ST_EM: begin
        if (div_rsp.done) begin
          out_nxt.mean_luma = mean_sat;
          out_nxt.cell_valid = 1'b1;
          out_nxt.highlight = mean_sat >= threshold_r;
          out_valid_nxt = 1'b1;
          state_nxt = ST_EO;
        end
      end
      ST_EO: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (col_r == IDX_W'(GRID_COLUMNS - 1)) begin
            col_vld_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            col_nxt = col_r + 1'b1;
            state_nxt = ST_EA;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      div_go_r <= 1'b0;
      px_r <= '0;
      py_r <= '0;
      gy_r <= '0;
      col_vld_r <= '0;
      col_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      div_go_r <= div_go_nxt;
      px_r <= px_nxt;
      py_r <= py_nxt;
      gy_r <= gy_nxt;
      col_vld_r <= col_vld_nxt;
      col_r <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    argb_r <= argb_nxt;
    gx_r <= gx_nxt;
    acc_r <= acc_nxt;
    luma_r <= luma_nxt;
    out_r <= out_nxt;
  end

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a cell mean is pending");

  a_hl_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.highlight || out_data.cell_valid))
    else $error("highlight set on an empty cell");

  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> col_r == IDX_W'(GRID_COLUMNS - 1))
    else $error("last flag on a column other than the final one");

  a_clear_after_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last |=> col_vld_r == '0 && in_ready)
    else $error("column sums not cleared after the cell row");
`endif

endmodule

@@ sim/grid_luma_statistics_top_tb.sv @@
module grid_luma_statistics_top_tb;
  import gls_pkg::*;

  localparam int NCOLS = 64;
  localparam int NROWS = 48;
  localparam int WMAX = 4096;
  localparam int HMAX = 4096;
  localparam int SETTLE_CYCLES = 300;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  grid_luma_statistics_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  in_t               pixel_q[$];
  out_t              cell_mean_q[$];
  logic [15:0]       srgb_lin[256];
  longint unsigned   col_sum[NCOLS];
  int unsigned       col_cnt[NCOLS];
  int unsigned       px_col;
  int unsigned       px_row;
  int unsigned       width_reg;
  int unsigned       height_reg;
  int unsigned       thr_reg;
  int                send_gap;
  int                recv_stall;
  int                errors;

  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [15:0] srgb_entry(int code);
    longint unsigned t, t2, lo, hi, mid, v, p2, p4;
    if (code <= 10) begin
      return 16'((longint'(code) * 6553600 + 164730) / 329460);
    end
    t = (((longint'(code) * 1000 + 14025) << 30) + 134512) / 269025;
    t2 = qmul(t, t);
    lo = 0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      p2 = qmul(mid, mid);
      p4 = qmul(p2, p2);
      if (qmul(p4, mid) <= t2) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    v = (qmul(t2, lo) + 8192) >> 14;
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int unsigned cell_index(int unsigned pos, int unsigned size,
                                             int unsigned cells);
    longint unsigned c;
    c = (longint'(cells) * pos) / size;
    return (c >= cells) ? cells - 1 : int'(c);
  endfunction

  task automatic accumulate_pixel(input in_t px);
    int unsigned     w, h, gx, gy, x, y, a, cnt;
    longint unsigned s, mean;
    out_t            r;
    w = clamp(width_reg, NCOLS, WMAX);
    h = clamp(height_reg, NROWS, HMAX);
    a = px.argb[31:24];
    if (px.frame_start) begin
      for (int c = 0; c < NCOLS; c++) begin
        col_sum[c] = 0;
        col_cnt[c] = 0;
      end
      px_col = 0;
      px_row = 0;
    end
    x = px_col;
    y = px_row;
    gx = cell_index(x, w, NCOLS);
    gy = cell_index(y, h, NROWS);
    if (a != 0) begin
      s = 64'd13933 * srgb_lin[px.argb[23:16]] + 64'd46871 * srgb_lin[px.argb[15:8]]
        + 64'd4732 * srgb_lin[px.argb[7:0]];
      col_sum[gx] += (s * a + 255 * 32768) / (255 * 65536);
      col_cnt[gx] += 1;
    end
    if (x + 1 >= w) begin
      if (y + 1 >= h || cell_index(y + 1, h, NROWS) != gy) begin
        for (int c = 0; c < NCOLS; c++) begin
          cnt = col_cnt[c];
          mean = cnt ? col_sum[c] / cnt : 0;
          if (mean > 65535) mean = 65535;
          r.cell_column = 6'(c);
          r.cell_row = 6'(gy);
          r.mean_luma = mean[15:0];
          r.cell_valid = (cnt != 0);
          r.highlight = (cnt != 0) && (mean >= thr_reg);
          r.last = (c == NCOLS - 1);
          cell_mean_q.insert(cell_mean_q.size(), r);
          col_sum[c] = 0;
          col_cnt[c] = 0;
        end
      end
      px_col = 0;
      px_row = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      px_col = x + 1;
    end
  endtask

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pixel_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pixel_q.pop_front();
        send_gap <= draw_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_stall <= 0;
    end else if (recv_stall > 0) begin
      out_ready <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else begin
      out_ready <= 1'b1;
      recv_stall <= draw_gap();
    end
  end

  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        accumulate_pixel(in_data);
      end
      if (out_valid && out_ready) begin
        if (cell_mean_q.size() == 0) begin
          $error("unexpected cell mean transaction: %p", out_data);
          errors++;
        end else begin
          exp_r = cell_mean_q.pop_front();
          if (out_data.cell_column !== exp_r.cell_column) begin
            $error("cell_column expected %0d got %0d", exp_r.cell_column, out_data.cell_column);
            errors++;
          end
          if (out_data.cell_row !== exp_r.cell_row) begin
            $error("cell_row expected %0d got %0d", exp_r.cell_row, out_data.cell_row);
            errors++;
          end
          if (out_data.mean_luma !== exp_r.mean_luma) begin
            $error("mean_luma expected %0d got %0d", exp_r.mean_luma, out_data.mean_luma);
            errors++;
          end
          if (out_data.cell_valid !== exp_r.cell_valid) begin
            $error("cell_valid expected %0d got %0d", exp_r.cell_valid, out_data.cell_valid);
            errors++;
          end
          if (out_data.highlight !== exp_r.highlight) begin
            $error("highlight expected %0d got %0d", exp_r.highlight, out_data.highlight);
            errors++;
          end
          if (out_data.last !== exp_r.last) begin
            $error("last expected %0d got %0d", exp_r.last, out_data.last);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH: width_reg = value & 32'h1FFF;
      REG_FRAME_HEIGHT: height_reg = value & 32'h1FFF;
      REG_HIGHLIGHT_THRESHOLD: thr_reg = value & 32'hFFFF;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pixel_q.size() > 0 || in_valid || cell_mean_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_pixel(input logic [31:0] argb, input logic fs);
    in_t p;
    p.argb = argb;
    p.frame_start = fs;
    pixel_q.insert(pixel_q.size(), p);
  endtask

  function automatic logic [31:0] rand_argb(int alpha_mode);
    logic [31:0] v;
    int          r;
    v = $urandom;
    r = (alpha_mode < 0) ? $urandom_range(0, 7) : alpha_mode;
    if (r == 0) v[31:24] = 8'h00;
    else if (r == 1) v[31:24] = 8'hFF;
    return v;
  endfunction

  task automatic queue_random(input int n, input int fs_pct);
    for (int i = 0; i < n; i++) begin
      queue_pixel(rand_argb(-1), $urandom_range(0, 99) < fs_pct);
    end
  endtask

  initial begin
    for (int i = 0; i < 256; i++) srgb_lin[i] = srgb_entry(i);
    for (int c = 0; c < NCOLS; c++) begin
      col_sum[c] = 0;
      col_cnt[c] = 0;
    end
    px_col = 0;
    px_row = 0;
    width_reg = FRAME_WIDTH_RST;
    height_reg = FRAME_HEIGHT_RST;
    thr_reg = HIGHLIGHT_THRESHOLD_RST;
    errors = 0;
    rst_n = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(REG_FRAME_WIDTH, 64);
    write_reg(REG_FRAME_HEIGHT, 48);
    write_reg(REG_HIGHLIGHT_THRESHOLD, 0);
    queue_pixel(32'h00000000, 1'b1);
    queue_pixel(32'hFFFFFFFF, 1'b0);
    queue_pixel(32'h00FFFFFF, 1'b0);
    queue_pixel(32'hFF000000, 1'b0);
    queue_pixel(32'hFF0A0A0A, 1'b0);
    queue_pixel(32'hFF0B0B0B, 1'b0);
    queue_pixel(32'hFFFF0000, 1'b0);
    queue_pixel(32'hFF00FF00, 1'b0);
    queue_pixel(32'hFF0000FF, 1'b0);
    queue_pixel(32'h01FFFFFF, 1'b0);
    queue_pixel(32'h80808080, 1'b0);
    queue_pixel(32'hFE010203, 1'b0);
    queue_pixel(32'h7F7F7F7F, 1'b0);
    queue_pixel(32'hAA555555, 1'b0);
    queue_pixel(32'h55AAAAAA, 1'b0);
    queue_pixel(32'hFFFFFFFF, 1'b1);
    queue_random(48, 0);
    wait_idle();

    write_reg(REG_HIGHLIGHT_THRESHOLD, 65535);
    for (int i = 0; i < 32; i++) queue_pixel({8'hFF, 24'hFFFFFF}, 1'b0);
    for (int i = 0; i < 32; i++) queue_pixel(rand_argb(0), 1'b0);
    wait_idle();

    write_reg(REG_HIGHLIGHT_THRESHOLD, $urandom_range(20000, 50000));
    queue_random(24, 3);
    wait_idle();

    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 8191);
    queue_random(6, 0);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 8191);
    write_reg(REG_FRAME_HEIGHT, 0);
    queue_random(6, 0);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 4096);
    write_reg(REG_FRAME_HEIGHT, 4096);
    queue_random(4, 0);
    wait_idle();

    write_reg(REG_FRAME_WIDTH, 65);
    write_reg(REG_FRAME_HEIGHT, 49);
    write_reg(REG_HIGHLIGHT_THRESHOLD, $urandom_range(0, 65535));
    queue_random(1, 100);
    queue_random(129, 0);
    wait_idle();

    if (errors == 0 && cell_mean_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
